FILE: rtl/natural_cubic_spline_second_derivs_core_assert.svh
// assertion macros shared by the spline solver rtl
`ifndef NATURAL_CUBIC_SPLINE_SECOND_DERIVS_CORE_ASSERT_SVH
`define NATURAL_CUBIC_SPLINE_SECOND_DERIVS_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define NCS_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ncs check failed");

// next-cycle implication
`define NCS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ncs check failed");

`endif

FILE: rtl/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg
// shared widths and types of the natural cubic spline solver
// ----------------------------------------------------------------------------
package ncs_pkg;

	localparam int DIV_NUM_W = 54;
	localparam int DIV_DEN_W = 19;
	localparam int DIV_CNT_W = 6;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/ncs_div.sv
// ----------------------------------------------------------------------------
// ncs_div
// bit-serial restoring divider, one quotient bit per cycle, unsigned operands
// ----------------------------------------------------------------------------
module ncs_div import ncs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic [DIV_NUM_W-1:0] quo,
	output div_stat_t            stat
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;

	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - DIV_CNT_W'(1);
			done_q <= cnt_q == DIV_CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in where numerator bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			num_q <= {num_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign quo       = num_q;
	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;

endmodule

FILE: rtl/natural_cubic_spline_second_derivs_core.sv
// nodes load one word per cycle while in the load state; a word without tlast gives no result
// a tlast word starts the solve: per interior node, node reads, then three
// serial divisions on the shared divider
// back substitution steps through read, x multiply, x add, y multiply and y add per node on one shared 32x32 multiplier
// results leave one word at a time, each held until m_tready; next run is taken after the last word
// arst_n clears the sequencer, node count and output valid; stores are not cleared
module natural_cubic_spline_second_derivs_core import ncs_pkg::*; #(
	parameter int MAX_NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // node_x [31:0], node_y [63:32]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // deriv_x [31:0], deriv_y [63:32]
	output logic        m_tlast
);

`include "natural_cubic_spline_second_derivs_core_assert.svh"

	localparam int AW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_RD    = 4'd1;
	localparam logic [3:0] ST_DIVC  = 4'd2;
	localparam logic [3:0] ST_DIVX  = 4'd3;
	localparam logic [3:0] ST_DIVY  = 4'd4;
	localparam logic [3:0] ST_BINIT = 4'd5;
	localparam logic [3:0] ST_BRD   = 4'd6;
	localparam logic [3:0] ST_BMX   = 4'd7;
	localparam logic [3:0] ST_BAX   = 4'd8;
	localparam logic [3:0] ST_BMY   = 4'd9;
	localparam logic [3:0] ST_BAY   = 4'd10;
	localparam logic [3:0] ST_ORD   = 4'd11;
	localparam logic [3:0] ST_OLD   = 4'd12;
	localparam logic [3:0] ST_OHOLD = 4'd13;

	function automatic logic [31:0] sat_quo(input logic [DIV_NUM_W-1:0] quo, input logic neg);
		logic [31:0] r;
		if (!neg) begin
			r = (quo > DIV_NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[31:0];
		end else begin
			r = (quo > DIV_NUM_W'(32'h8000_0000)) ? 32'h8000_0000 : (~quo[31:0] + 32'd1);
		end
		return r;
	endfunction

	// (p / 2^16 rounded toward zero) + u, clamped to 32 bits
	function automatic logic [31:0] back_sum(input logic signed [63:0] p, input logic [31:0] u);
		logic signed [47:0] sh;
		logic signed [48:0] s;
		logic [31:0]        r;
		sh = 48'(p >>> 16) + ((p[63] && (p[15:0] != 16'd0)) ? 48'sd1 : 48'sd0);
		s  = $signed({sh[47], sh}) + $signed({{17{u[31]}}, u});
		if (s > 49'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (s < -49'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	logic [3:0]    state_q;
	logic [1:0]    ph_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] idx_q;
	logic          out_valid_q;

	logic [63:0] a_q, b_q, d_q;
	logic signed [34:0] diffx_q, diffy_q;
	logic signed [37:0] tx_q, ty_q;
	logic signed [31:0] c_prev_q, ux_prev_q, uy_prev_q, c_new_q, ux_new_q;
	logic signed [31:0] mnx_q, mny_q, mx_q;
	logic signed [63:0] prod_q;
	logic [63:0] out_data_q;
	logic        out_last_q;

	logic [63:0] node_mem [MAX_NODES];
	logic [63:0] fac_mem  [MAX_NODES];
	logic [63:0] rhs_mem  [MAX_NODES];
	logic [63:0] node_rd, fac_rd, rhs_rd;

	logic          accept, last_acc, room;
	logic [CW-1:0] n_new;
	logic          fac_we, rhs_we;
	logic [AW-1:0] fac_waddr;
	logic [63:0]   fac_wdata, rhs_wdata;
	logic [AW-1:0] node_raddr;

	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_NUM_W-1:0] div_quo;
	div_stat_t            div_stat;

	logic [37:0]   tx_mag, ty_mag;
	logic [31:0]   uy_new, my_new;
	logic          fwd_more, out_last;
	logic signed [37:0] dx38, dy38;

	assign s_tready = state_q == ST_LOAD;
	assign accept   = s_tvalid && s_tready;
	assign last_acc = accept && s_tlast;
	assign room     = count_q < CW'(MAX_NODES);
	assign n_new    = room ? count_q + CW'(1) : count_q;

	assign fwd_more = ({1'b0, CW'(idx_q)} + (CW+1)'(2)) < {1'b0, n_q};
	assign out_last = (CW'(idx_q) + CW'(1)) == n_q;

	assign tx_mag = tx_q[37] ? 38'(-tx_q) : 38'(tx_q);
	assign ty_mag = ty_q[37] ? 38'(-ty_q) : 38'(ty_q);
	assign uy_new = sat_quo(div_quo, ty_q[37]);
	assign my_new = back_sum(prod_q, rhs_rd[63:32]);

	assign dx38 = {{3{diffx_q[34]}}, diffx_q};
	assign dy38 = {{3{diffy_q[34]}}, diffy_q};

	// one shared divider: factor, then x term, then y term
	assign div_start = (state_q == ST_RD && ph_q == 2'd3) ||
		(state_q == ST_DIVC && div_stat.done) || (state_q == ST_DIVX && div_stat.done);

	always_comb begin
		case (state_q)
			ST_RD:   div_num = DIV_NUM_W'(64'h1_0000_0000);
			ST_DIVC: div_num = {tx_mag, 16'd0};
			default: div_num = {ty_mag, 16'd0};
		endcase
	end

	// twice the pivot: c[i-1] + 4.0
	assign div_den = DIV_DEN_W'(c_prev_q + 32'sd262144);

	ncs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	assign node_raddr = AW'(idx_q + AW'(ph_q) - AW'(1));

	always_comb begin
		fac_we    = 1'b0;
		rhs_we    = 1'b0;
		fac_waddr = idx_q;
		fac_wdata = '0;
		rhs_wdata = '0;
		case (state_q)
			ST_LOAD: begin
				fac_we    = last_acc;
				rhs_we    = last_acc;
				fac_waddr = '0;
			end
			ST_DIVY: begin
				fac_we    = div_stat.done;
				rhs_we    = div_stat.done;
				fac_wdata = {c_new_q, c_new_q};
				rhs_wdata = {uy_new, ux_new_q};
			end
			ST_BINIT: begin
				fac_we    = 1'b1;
				fac_waddr = AW'(n_q - CW'(1));
			end
			ST_BAY: begin
				fac_we    = 1'b1;
				fac_wdata = {my_new, mx_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && room) begin
			node_mem[count_q[AW-1:0]] <= s_tdata;
		end
		if (state_q == ST_RD && ph_q != 2'd3) begin
			node_rd <= node_mem[node_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (fac_we) begin
			fac_mem[fac_waddr] <= fac_wdata;
		end
		if (state_q == ST_BRD || state_q == ST_ORD) begin
			fac_rd <= fac_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (rhs_we) begin
			rhs_mem[fac_waddr] <= rhs_wdata;
		end
		if (state_q == ST_BRD) begin
			rhs_rd <= rhs_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			ph_q        <= '0;
			count_q     <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						count_q <= n_new;
						if (s_tlast) begin
							count_q <= '0;
							n_q     <= n_new;
							idx_q   <= AW'(1);
							ph_q    <= '0;
							state_q <= (n_new > CW'(2)) ? ST_RD : ST_BINIT;
						end
					end
				end
				ST_RD: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						state_q <= ST_DIVC;
					end
				end
				ST_DIVC: begin
					if (div_stat.done) begin
						state_q <= ST_DIVX;
					end
				end
				ST_DIVX: begin
					if (div_stat.done) begin
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (div_stat.done) begin
						idx_q   <= idx_q + AW'(1);
						ph_q    <= '0;
						state_q <= fwd_more ? ST_RD : ST_BINIT;
					end
				end
				ST_BINIT: begin
					idx_q   <= AW'(n_q - CW'(2));
					state_q <= (n_q == CW'(1)) ? ST_ORD : ST_BRD;
					if (n_q == CW'(1)) begin
						idx_q <= '0;
					end
				end
				ST_BRD:  state_q <= ST_BMX;
				ST_BMX:  state_q <= ST_BAX;
				ST_BAX:  state_q <= ST_BMY;
				ST_BMY:  state_q <= ST_BAY;
				ST_BAY: begin
					if (idx_q == '0) begin
						state_q <= ST_ORD;
					end else begin
						idx_q   <= idx_q - AW'(1);
						state_q <= ST_BRD;
					end
				end
				ST_ORD:  state_q <= ST_OLD;
				ST_OLD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OHOLD;
				end
				ST_OHOLD: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= ST_LOAD;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (last_acc) begin
			c_prev_q  <= '0;
			ux_prev_q <= '0;
			uy_prev_q <= '0;
		end
		if (state_q == ST_RD) begin
			case (ph_q)
				2'd1:    a_q <= node_rd;
				2'd2:    b_q <= node_rd;
				2'd3:    d_q <= node_rd;
				default: ;
			endcase
		end
		// second differences, then 6 D - u[i-1]; settled long before the divide ends
		if (state_q == ST_DIVC) begin
			diffx_q <= $signed({{3{a_q[31]}}, a_q[31:0]}) + $signed({{3{d_q[31]}}, d_q[31:0]})
				- $signed({{2{b_q[31]}}, b_q[31:0], 1'b0});
			diffy_q <= $signed({{3{a_q[63]}}, a_q[63:32]}) + $signed({{3{d_q[63]}}, d_q[63:32]})
				- $signed({{2{b_q[63]}}, b_q[63:32], 1'b0});
			tx_q    <= (dx38 <<< 2) + (dx38 <<< 1) - 38'(ux_prev_q);
			ty_q    <= (dy38 <<< 2) + (dy38 <<< 1) - 38'(uy_prev_q);
			if (div_stat.done) begin
				c_new_q <= -$signed(div_quo[31:0]);
			end
		end
		if (state_q == ST_DIVX && div_stat.done) begin
			ux_new_q <= sat_quo(div_quo, tx_q[37]);
		end
		if (state_q == ST_DIVY && div_stat.done) begin
			c_prev_q  <= c_new_q;
			ux_prev_q <= ux_new_q;
			uy_prev_q <= uy_new;
		end
		if (state_q == ST_BINIT) begin
			mnx_q <= '0;
			mny_q <= '0;
		end
		if (state_q == ST_BMX) begin
			prod_q <= $signed(fac_rd[31:0]) * mnx_q;
		end
		if (state_q == ST_BAX) begin
			mx_q <= back_sum(prod_q, rhs_rd[31:0]);
		end
		if (state_q == ST_BMY) begin
			prod_q <= $signed(fac_rd[63:32]) * mny_q;
		end
		if (state_q == ST_BAY) begin
			mnx_q <= mx_q;
			mny_q <= my_new;
		end
		if (state_q == ST_OLD) begin
			out_data_q <= fac_rd;
			out_last_q <= out_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	`NCS_ASSERT_IMPL(a_rdy_idle, s_tready, !m_tvalid && !div_stat.busy)
	`NCS_ASSERT_IMPL(a_cnt_max, 1'b1, count_q <= CW'(MAX_NODES))
	`NCS_ASSERT_IMPL(a_div_free, div_start, !div_stat.busy)
	`NCS_ASSERT_NEXT(a_done_pulse, div_stat.done, !div_stat.done)
	`NCS_ASSERT_IMPL(a_last_pos, m_tvalid && m_tlast, (CW'(idx_q) + CW'(1)) == n_q)

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// spline second derivative solver testbench
// streams runs of 2-D nodes into the solver and checks every derivative word
// against a predictor of the uniform natural cubic spline solve
// ----------------------------------------------------------------------------
class spline_scoreboard;
	logic signed [63:0] xs[$];
	logic signed [63:0] ys[$];
	logic [64:0] pending[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	static function logic signed [63:0] sat32(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// tridiagonal solve of one coordinate, returns second derivatives
	static function void solve_axis(input logic signed [63:0] pts[$],
		output logic signed [63:0] m[64]);
		logic signed [63:0] c[64];
		logic signed [63:0] u[64];
		logic signed [63:0] q;
		logic signed [63:0] d;
		int n;
		n = pts.size();
		c[0] = 0;
		u[0] = 0;
		for (int i = 1; i + 1 < n; i++) begin
			// twice the pivot, c[i-1] + 4.0 in Q16.16
			q = c[i-1] + 64'sd262144;
			d = pts[i+1] - 2 * pts[i] + pts[i-1];
			c[i] = -64'sd4294967296 / q;
			u[i] = sat32(((6 * d - u[i-1]) * 64'sd65536) / q);
		end
		m[n-1] = 0;
		for (int i = n - 2; i >= 0; i--)
			m[i] = sat32((c[i] * m[i+1]) / 64'sd65536 + u[i]);
	endfunction

	function void note_node(logic [31:0] x, logic [31:0] y, logic last);
		logic signed [63:0] mx[64];
		logic signed [63:0] my[64];
		int n;
		if (xs.size() < 64) begin
			xs.push_back(64'(signed'(x)));
			ys.push_back(64'(signed'(y)));
		end
		if (!last)
			return;
		n = xs.size();
		solve_axis(xs, mx);
		solve_axis(ys, my);
		for (int i = 0; i < n; i++)
			pending.push_back({i == n - 1, my[i][31:0], mx[i][31:0]});
		xs = {};
		ys = {};
	endfunction

	function void check_word(logic [63:0] data, logic last);
		logic [64:0] want;
		if (pending.size() == 0) begin
			$display("%0t unexpected word: expected none, actual %h last %b",
				$time, data, last);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (want[31:0] !== data[31:0]) begin
			$display("%0t deriv_x: expected %h, actual %h", $time, want[31:0], data[31:0]);
			errors++;
		end
		if (want[63:32] !== data[63:32]) begin
			$display("%0t deriv_y: expected %h, actual %h", $time, want[63:32],
				data[63:32]);
			errors++;
		end
		if (want[64] !== last) begin
			$display("%0t last_out: expected %b, actual %b", $time, want[64], last);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tlast;

	spline_scoreboard sb;
	int node_total;
	bit calm;

	natural_cubic_spline_second_derivs_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		calm = 1'b0;
		node_total = 0;
	end

	// sender side: optional random gap, then drive one word, hold until taken
	task automatic send_node(logic [31:0] x, logic [31:0] y, logic last);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_node(x, y, last);
		node_total++;
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'(int'($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	task automatic send_run(int n, int mode);
		for (int i = 0; i < n; i++)
			send_node(rand_coord(mode), rand_coord(mode), i == n - 1);
	endtask

	// result side with random stall bursts
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tlast);
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 15);
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin
		int n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: short runs, extremes, full store with dropped nodes
		send_run(1, 2);
		send_run(2, 2);
		send_node(32'h7fffffff, 32'h80000000, 1'b0);
		send_node(32'h80000000, 32'h7fffffff, 1'b0);
		send_node(32'h7fffffff, 32'h80000000, 1'b1);
		send_node(32'h00000000, 32'hffffffff, 1'b0);
		send_node(32'hffffffff, 32'h00000000, 1'b0);
		send_node(32'h55555555, 32'haaaaaaaa, 1'b0);
		send_node(32'haaaaaaaa, 32'h55555555, 1'b1);
		send_run(66, 2);
		// random runs, mostly short, a few long ones of 40 to 64 nodes
		while (node_total < 360) begin
			if (node_total > 300)
				calm = 1'b1;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 10);
			send_run(n, $urandom_range(0, 3));
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#30000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule

FILE: natural_cubic_spline_second_derivs_core.f
+incdir+rtl
rtl/ncs_pkg.sv
rtl/ncs_div.sv
rtl/natural_cubic_spline_second_derivs_core.sv
dv/tb_top.sv
